FILE: hdl/kfpt_pkg.sv
// ----------------------------------------------------------------------------
// kfpt_pkg
// Shared sizes, codes and controller/datapath interface types of the key
// frequency percentile table.
// ----------------------------------------------------------------------------
package kfpt_pkg;

  // table size and derived widths
  localparam int MAX_KEYS = 256;
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  // percent scale and threshold product width
  localparam int PCT_W      = 14;
  localparam int PCT_FULL   = 10000;
  localparam int PROD_W     = PCT_W + 32;

  // operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_FIND = 2'd1;
  localparam logic [1:0] OP_PCT  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic       accept;
    logic       ptr_inc;
    logic       ptr_dec;
    logic       rd_prev;
    logic       scan_done;
    logic       cnt_inc;
    logic       shift_wr;
    logic       insert;
    logic       mul;
    logic       walk_acc;
    logic       set_status;
    logic [1:0] status;
    logic       set_count;
    logic       set_key;
    logic       out_load;
  } kfpt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       ptr_at_end;
    logic       ptr_at_pos;
    logic       key_lt;
    logic       key_eq;
    logic       full;
    logic       total_zero;
    logic       run_hit;
    logic       out_free;
  } kfpt_stat_t;

endpackage

FILE: hdl/kfpt_datapath.sv
// ----------------------------------------------------------------------------
// kfpt_datapath
// Key and count memories, scan pointer, counters, percentile threshold
// compare, remaining-gap register and result register.
// ----------------------------------------------------------------------------
module kfpt_datapath
  import kfpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  kfpt_cmd_t           cmd,
  output kfpt_stat_t          stat,
  input  logic [1:0]          in_op,
  input  logic signed [31:0]  in_key,
  input  logic [PCT_W-1:0]    in_percent_hundredths,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_key_out,
  output logic [31:0]         out_key_count,
  output logic [31:0]         out_total_count,
  output logic [8:0]          out_distinct_count
);

  logic [31:0] keys_mem [MAX_KEYS];
  logic [31:0] cnts_mem [MAX_KEYS];

  logic [1:0]         op_r;
  logic [31:0]        key_r;
  logic [PCT_W-1:0]   pct_r;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   pos_r;
  logic [31:0]        total_r, total_nxt;
  logic [CNT_W-1:0]   dist_r, dist_nxt;
  logic [PROD_W-1:0]  gap_r;
  logic [31:0]        rd_key_r, rd_cnt_r;
  logic [1:0]         res_status_r;
  logic [31:0]        res_key_r, res_cnt_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [31:0]        out_key_r, out_cnt_r, out_total_r;
  logic [CNT_W-1:0]   out_dist_r;

  logic [CNT_W-1:0]   rd_ptr;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic               key_we, cnt_we;
  logic [31:0]        key_wd, cnt_wd;
  logic [PCT_W-1:0]   pct_c;
  logic [PROD_W-1:0]  cnt_prod;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // memory addressing
  assign rd_ptr  = cmd.rd_prev ? ptr_r - CNT_W'(1) : ptr_r;
  assign rd_addr = rd_ptr[IDX_W-1:0];

  always_comb begin
    key_we  = cmd.shift_wr | cmd.insert;
    cnt_we  = cmd.shift_wr | cmd.insert | cmd.cnt_inc;
    wr_addr = cmd.insert ? pos_r[IDX_W-1:0] : ptr_r[IDX_W-1:0];
    key_wd  = cmd.insert ? key_r : rd_key_r;
    if (cmd.insert) begin
      cnt_wd = 32'd1;
    end else if (cmd.cnt_inc) begin
      cnt_wd = sat_inc(rd_cnt_r);
    end else begin
      cnt_wd = rd_cnt_r;
    end
  end

  // table memories with registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      keys_mem[wr_addr] <= key_wd;
    end
    if (cnt_we) begin
      cnts_mem[wr_addr] <= cnt_wd;
    end
    rd_key_r <= keys_mem[rd_addr];
    rd_cnt_r <= cnts_mem[rd_addr];
  end

  // pointer and counters
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.accept) begin
      ptr_nxt = '0;
    end else if (cmd.scan_done) begin
      ptr_nxt = dist_r;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end else if (cmd.ptr_dec) begin
      ptr_nxt = ptr_r - CNT_W'(1);
    end
    total_nxt = total_r;
    dist_nxt  = dist_r;
    if (cmd.insert || cmd.cnt_inc) begin
      total_nxt = sat_inc(total_r);
    end
    if (cmd.insert) begin
      dist_nxt = dist_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      total_r <= '0;
      dist_r  <= '0;
    end else begin
      ptr_r   <= ptr_nxt;
      total_r <= total_nxt;
      dist_r  <= dist_nxt;
    end
  end

  // threshold without a divide: run >= floor(P/10000) exactly when
  // run*10000 + 9999 >= P, so the gap P - 10000*(counts so far) is tracked
  assign pct_c    = (pct_r > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_r;
  assign cnt_prod = PROD_W'(rd_cnt_r) * PROD_W'(PCT_FULL);

  // item capture, gap register and result fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= in_op;
      key_r        <= in_key;
      pct_r        <= in_percent_hundredths;
      res_status_r <= ST_OK;
      res_key_r    <= '0;
      res_cnt_r    <= '0;
    end
    if (cmd.scan_done) begin
      pos_r <= ptr_r;
    end
    if (cmd.mul) begin
      gap_r <= PROD_W'(pct_c) * PROD_W'(total_r);
    end else if (cmd.walk_acc) begin
      gap_r <= gap_r - cnt_prod;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    if (cmd.set_count) begin
      res_cnt_r <= rd_cnt_r;
    end
    if (cmd.set_key) begin
      res_key_r <= rd_key_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_cnt_r    <= res_cnt_r;
      out_total_r  <= total_r;
      out_dist_r   <= dist_r;
    end
  end

  // status to controller
  always_comb begin
    stat.op         = op_r;
    stat.ptr_at_end = (ptr_r == dist_r);
    stat.ptr_at_pos = (ptr_r == pos_r);
    stat.key_lt     = $signed(rd_key_r) < $signed(key_r);
    stat.key_eq     = (rd_key_r == key_r);
    stat.full       = (dist_r == CNT_W'(MAX_KEYS));
    stat.total_zero = (total_r == 32'd0);
    stat.run_hit    = (cnt_prod + PROD_W'(PCT_FULL - 1)) >= gap_r;
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_key_out        = out_key_r;
  assign out_key_count      = out_cnt_r;
  assign out_total_count    = out_total_r;
  assign out_distinct_count = 9'(out_dist_r);

endmodule

FILE: hdl/kfpt_ctrl.sv
// ----------------------------------------------------------------------------
// kfpt_ctrl
// Sequencer for search, shift-insert, threshold product and percentile walk.
// ----------------------------------------------------------------------------
module kfpt_ctrl
  import kfpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output kfpt_cmd_t  cmd,
  input  kfpt_stat_t stat
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECODE   = 10'b00_0000_0010,
    S_SCAN_RD  = 10'b00_0000_0100,
    S_SCAN_CMP = 10'b00_0000_1000,
    S_SHIFT_RD = 10'b00_0001_0000,
    S_SHIFT_WR = 10'b00_0010_0000,
    S_INSERT   = 10'b00_0100_0000,
    S_MUL      = 10'b00_1000_0000,
    S_WALK_RD  = 10'b01_0000_0000,
    S_WALK_CMP = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  assign in_ready = (state_r == S_IDLE) && !done_r;

  // key not held: find misses, add inserts unless full
  function automatic void miss(input logic [1:0] op, input logic full,
                               inout kfpt_cmd_t c, inout state_t s, inout logic d);
    if (op == OP_FIND) begin
      c.set_status = 1'b1;
      c.status     = ST_NOT_FOUND;
      d            = 1'b1;
      s            = S_IDLE;
    end else if (full) begin
      c.set_status = 1'b1;
      c.status     = ST_FULL;
      d            = 1'b1;
      s            = S_IDLE;
    end else begin
      c.scan_done = 1'b1;
      s           = S_SHIFT_RD;
    end
  endfunction

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    done_nxt  = done_r;
    if (done_r) begin
      if (stat.out_free) begin
        cmd.out_load = 1'b1;
        done_nxt     = 1'b0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_nxt  = S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (stat.op)
            OP_ADD, OP_FIND: state_nxt = S_SCAN_RD;
            OP_PCT: begin
              if (stat.total_zero) begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_EMPTY;
                done_nxt       = 1'b1;
                state_nxt      = S_IDLE;
              end else begin
                state_nxt = S_MUL;
              end
            end
            default: begin
              done_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
        S_SCAN_RD: begin
          if (stat.ptr_at_end) begin
            miss(stat.op, stat.full, cmd, state_nxt, done_nxt);
          end else begin
            state_nxt = S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (stat.key_lt) begin
            cmd.ptr_inc = 1'b1;
            state_nxt   = S_SCAN_RD;
          end else if (stat.key_eq) begin
            if (stat.op == OP_FIND) begin
              cmd.set_count = 1'b1;
            end else begin
              cmd.cnt_inc = 1'b1;
            end
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            miss(stat.op, stat.full, cmd, state_nxt, done_nxt);
          end
        end
        S_SHIFT_RD: begin
          cmd.rd_prev = 1'b1;
          state_nxt   = stat.ptr_at_pos ? S_INSERT : S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          cmd.shift_wr = 1'b1;
          cmd.ptr_dec  = 1'b1;
          state_nxt    = S_SHIFT_RD;
        end
        S_INSERT: begin
          cmd.insert = 1'b1;
          done_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
        S_MUL: begin
          cmd.mul   = 1'b1;
          state_nxt = S_WALK_RD;
        end
        S_WALK_RD: begin
          if (stat.ptr_at_end) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_NOT_FOUND;
            done_nxt       = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_WALK_CMP;
          end
        end
        S_WALK_CMP: begin
          cmd.walk_acc = 1'b1;
          if (stat.run_hit) begin
            cmd.set_key = 1'b1;
            done_nxt    = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_nxt   = S_WALK_RD;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

FILE: hdl/key_frequency_percentile_table.sv
// ----------------------------------------------------------------------------
// key_frequency_percentile_table
// Sorted table of signed keys with occurrence counts and percentile lookup.
// ----------------------------------------------------------------------------
// One item at a time. Add and find scan the sorted key memory from slot 0,
// reading and then comparing each slot visited; an add of a new key then
// shifts the entries above its slot up one place, reading and writing each
// in turn, before the insert. A percentile query first forms pct*total in
// its multiply state, and the floor of its division by 10000 is folded into
// the running compare of the walk. The result register lets the next item
// enter while a result waits; a finished item waits only if the previous
// result is still untaken. The table needs no clearing after reset.
module key_frequency_percentile_table
  import kfpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_key,
  input  logic [13:0]        in_percent_hundredths,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_key_out,
  output logic [31:0]        out_key_count,
  output logic [31:0]        out_total_count,
  output logic [8:0]         out_distinct_count
);

  kfpt_cmd_t  cmd;
  kfpt_stat_t stat;

  // sequencer
  kfpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // storage and arithmetic
  kfpt_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_op                 (in_op),
    .in_key                (in_key),
    .in_percent_hundredths (in_percent_hundredths),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_key_out           (out_key_out),
    .out_key_count         (out_key_count),
    .out_total_count       (out_total_count),
    .out_distinct_count    (out_distinct_count)
  );

  // distinct count never exceeds capacity
  a_dist_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distinct_count <= 9'(MAX_KEYS))
    else $error("distinct count above capacity");

  // full only with a full table
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_distinct_count == 9'(MAX_KEYS))
    else $error("full status with free slots");

  // empty only with zero total
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_total_count == 32'd0)
    else $error("empty status with nonzero total");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key frequency percentile table. A behavioral
// model of the sorted table predicts every result. Items are sent with random
// gaps and results are taken with random stalls. A long receiver stall fills
// the block, and the table is run up to full.
// ----------------------------------------------------------------------------
module tb;
  import kfpt_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] key_out;
    logic [31:0]        key_count;
    logic [31:0]        total;
    logic [8:0]         distinct;
  } table_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_op;
  logic signed [31:0] in_key;
  logic [13:0]        in_percent_hundredths;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic signed [31:0] out_key_out;
  logic [31:0]        out_key_count;
  logic [31:0]        out_total_count;
  logic [8:0]         out_distinct_count;

  // shadow copy of the table
  logic signed [31:0] shadow_keys [MAX_KEYS];
  logic [31:0]        shadow_counts [MAX_KEYS];
  int                 shadow_distinct;
  logic [31:0]        shadow_total;

  table_result_t      pending_results[$];
  logic signed [31:0] key_pool[64];
  int                 error_count;
  int                 stall_hold;

  key_frequency_percentile_table dut (.*);

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // update the shadow table for one item and return the expected result
  function automatic table_result_t table_predict(input logic [1:0] op,
                                                  input logic signed [31:0] key,
                                                  input logic [13:0] pct);
    table_result_t r;
    int            pos;
    logic [63:0]   threshold;
    logic [63:0]   run;
    logic [13:0]   pct_c;
    r.status = ST_OK;
    r.key_out = '0;
    r.key_count = '0;
    pos = 0;
    while (pos < shadow_distinct && shadow_keys[pos] < key) pos++;
    case (op)
      OP_ADD: begin
        if (pos < shadow_distinct && shadow_keys[pos] == key) begin
          shadow_counts[pos] = sat_inc(shadow_counts[pos]);
          shadow_total = sat_inc(shadow_total);
        end else if (shadow_distinct >= MAX_KEYS) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_distinct; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_counts[i] = shadow_counts[i-1];
          end
          shadow_keys[pos] = key;
          shadow_counts[pos] = 32'd1;
          shadow_distinct++;
          shadow_total = sat_inc(shadow_total);
        end
      end
      OP_FIND: begin
        if (pos < shadow_distinct && shadow_keys[pos] == key) r.key_count = shadow_counts[pos];
        else r.status = ST_NOT_FOUND;
      end
      OP_PCT: begin
        if (shadow_total == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pct_c = (pct > PCT_FULL) ? 14'(PCT_FULL) : pct;
          threshold = (64'(pct_c) * 64'(shadow_total)) / 64'(PCT_FULL);
          run = '0;
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < shadow_distinct; i++) begin
            run += 64'(shadow_counts[i]);
            if (run >= threshold) begin
              r.key_out = shadow_keys[i];
              r.status = ST_OK;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.total = shadow_total;
    r.distinct = 9'(shadow_distinct);
    return r;
  endfunction

  // send one item after a random gap, predicting it when it is taken
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] key,
                           input logic [13:0] pct);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    in_percent_hundredths <= pct;
    do @(negedge clk); while (!in_ready);
    pending_results.push_back(table_predict(op, key, pct));
    @(posedge clk);
  endtask

  // result side: random stalls, optional long hold, field checks
  initial begin
    table_result_t exp_r;
    int            gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_hold > 0) begin
        out_ready <= 1'b0;
        repeat (stall_hold) @(posedge clk);
        stall_hold = 0;
      end
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $display("unexpected result item at %0t", $realtime);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) report("status", 32'(out_status), 32'(exp_r.status));
        if (out_key_out !== exp_r.key_out) report("key_out", out_key_out, exp_r.key_out);
        if (out_key_count !== exp_r.key_count) report("key_count", out_key_count, exp_r.key_count);
        if (out_total_count !== exp_r.total) report("total_count", out_total_count, exp_r.total);
        if (out_distinct_count !== exp_r.distinct)
          report("distinct_count", 32'(out_distinct_count), 32'(exp_r.distinct));
      end
      @(posedge clk);
    end
  end

  function automatic logic [13:0] rand_pct();
    if ($urandom_range(0, 4) == 0) return 14'($urandom_range(0, 16383));
    return 14'($urandom_range(0, PCT_FULL));
  endfunction

  // empty table, unused op, key extremes, duplicates, percent edges
  task automatic test_directed();
    send_item(OP_FIND, 32'sd0, '0);
    send_item(OP_PCT, 32'sd0, 14'd5000);
    send_item(OP_NONE, 32'sh7FFF_FFFF, 14'h3FFF);
    send_item(OP_ADD, 32'sh8000_0000, '0);
    send_item(OP_ADD, 32'sh7FFF_FFFF, '0);
    send_item(OP_ADD, 32'sd0, '0);
    send_item(OP_ADD, -32'sd1, '0);
    send_item(OP_ADD, 32'sh7FFF_FFFF, '0);
    send_item(OP_ADD, 32'sh7FFF_FFFF, '0);
    send_item(OP_ADD, 32'sh8000_0000, '0);
    send_item(OP_FIND, 32'sh7FFF_FFFF, '0);
    send_item(OP_FIND, 32'sh8000_0000, '0);
    send_item(OP_FIND, 32'sd5, '0);
    send_item(OP_PCT, '0, 14'd0);
    send_item(OP_PCT, '0, 14'd1);
    send_item(OP_PCT, '0, 14'd5000);
    send_item(OP_PCT, '0, 14'd9999);
    send_item(OP_PCT, '0, 14'd10000);
    send_item(OP_PCT, '0, 14'h3FFF);
    send_item(OP_NONE, 32'sh8000_0000, 14'h2AAA);
  endtask

  // receiver holds off while items keep coming
  task automatic test_backpressure();
    stall_hold = 400;
    repeat (12) send_item(2'($urandom_range(0, 2)), key_pool[$urandom_range(0, 63)], rand_pct());
  endtask

  // mixed traffic, keys mostly from a small pool so counts build up
  task automatic test_random_mix(input int n_items);
    logic [1:0]         op;
    logic signed [31:0] key;
    int                 pick;
    repeat (n_items) begin
      pick = $urandom_range(0, 9);
      op = (pick < 5) ? OP_ADD : (pick < 7) ? OP_FIND : (pick < 9) ? OP_PCT : OP_NONE;
      key = ($urandom_range(0, 6) == 0) ? 32'($urandom) : key_pool[$urandom_range(0, 63)];
      send_item(op, key, rand_pct());
    end
  endtask

  // add new keys until the table is full, then probe full behavior
  task automatic test_fill_table();
    while (shadow_distinct < MAX_KEYS) send_item(OP_ADD, 32'($urandom), '0);
    send_item(OP_ADD, 32'($urandom), '0);
    send_item(OP_ADD, 32'sh7FFF_FFFF, '0);
    send_item(OP_PCT, '0, 14'd10000);
    send_item(OP_PCT, '0, 14'd0);
    send_item(OP_FIND, shadow_keys[MAX_KEYS-1], '0);
  endtask

  initial begin
    error_count = 0;
    stall_hold = 0;
    shadow_distinct = 0;
    shadow_total = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= '0;
    in_key <= '0;
    in_percent_hundredths <= '0;
    foreach (key_pool[i]) key_pool[i] = 32'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_mix(1150);
    test_fill_table();
    test_random_mix(340);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
